[rtl/jacs_pkg.sv]
// ----------------------------------------------------------------------------
// jacs_pkg
// Shared types, opcodes and constants of the joystick axis curve smoother.
// ----------------------------------------------------------------------------
package jacs_pkg;

   localparam int LOG_FRAC = 24;
   localparam int STEP_W   = 5;
   localparam int AXIS_W   = 16;
   localparam int POWER_W  = 12;
   localparam int ALPHA_W  = 17;
   localparam int CSR_W    = 17;

   localparam logic [POWER_W-1:0] POWER_ONE = 12'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   // request codes (3 acts as smooth)
   localparam logic [1:0] REQ_SMOOTH = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_SNAP   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_STEER_POWER = 2'd0;
   localparam logic [1:0] CSR_THR_POWER   = 2'd1;
   localparam logic [1:0] CSR_STEER_ALPHA = 2'd2;
   localparam logic [1:0] CSR_THR_ALPHA   = 2'd3;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD_IN = 4'd1;
   localparam logic [3:0] OP_PREP    = 4'd2;
   localparam logic [3:0] OP_NORM    = 4'd3;
   localparam logic [3:0] OP_LOG     = 4'd4;
   localparam logic [3:0] OP_NLOG    = 4'd5;
   localparam logic [3:0] OP_EMUL    = 4'd6;
   localparam logic [3:0] OP_EXP     = 4'd7;
   localparam logic [3:0] OP_SCALE   = 4'd8;
   localparam logic [3:0] OP_DIFF    = 4'd9;
   localparam logic [3:0] OP_WEIGH   = 4'd10;
   localparam logic [3:0] OP_UPDATE  = 4'd11;
   localparam logic [3:0] OP_OUT     = 4'd12;

   typedef struct packed {
      logic [3:0]        op;
      logic [1:0]        axis;
      logic [STEP_W-1:0] step;
   } jacs_cmd_type;

   typedef struct packed {
      logic shortcut;
      logic norm_done;
   } jacs_status_type;

   typedef logic [LOG_FRAC-1:0][31:0] jacs_root_tab_type;

   // Chain of square roots: c(k) = floor(sqrt(c(k-1) * 2^32)), c(0) = 2^31.
   function automatic jacs_root_tab_type exp_roots();
      jacs_root_tab_type tab;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      logic [31:0] c;
      c = 32'h8000_0000;
      for (int k = 0; k < LOG_FRAC; k++) begin
         v = {c, 32'h0};
         r = 64'h0;
         b = 64'h4000_0000_0000_0000;
         for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         c = r[31:0];
         tab[k] = c;
      end
      return tab;
   endfunction

   localparam jacs_root_tab_type EXP_ROOT = exp_roots();

endpackage

[rtl/jacs_ctrl.sv]
// ----------------------------------------------------------------------------
// jacs_ctrl
// Sequencer: walks the four axes through shaping and blending, then hands
// the result to the output register.
// ----------------------------------------------------------------------------
module jacs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  jacs_pkg::jacs_status_type status,
   output jacs_pkg::jacs_cmd_type    cmd
);
   import jacs_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_NORM   = 4'd2;
   localparam logic [3:0] ST_LOG    = 4'd3;
   localparam logic [3:0] ST_NLOG   = 4'd4;
   localparam logic [3:0] ST_EMUL   = 4'd5;
   localparam logic [3:0] ST_EXP    = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_DIFF   = 4'd8;
   localparam logic [3:0] ST_WEIGH  = 4'd9;
   localparam logic [3:0] ST_UPDATE = 4'd10;
   localparam logic [3:0] ST_FINISH = 4'd11;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LOG_FRAC - 1);

   logic [3:0]        state_ff, state_in;
   logic [1:0]        axis_ff, axis_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              out_free;
   logic [3:0]        op;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD_IN;
               axis_in  = 2'd0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            op       = OP_PREP;
            state_in = status.shortcut ? ST_DIFF : ST_NORM;
         end
         ST_NORM: begin
            op = OP_NORM;
            if (status.norm_done) begin
               step_in  = '0;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            op      = OP_LOG;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = ST_NLOG;
         end
         ST_NLOG: begin
            op       = OP_NLOG;
            state_in = ST_EMUL;
         end
         ST_EMUL: begin
            op       = OP_EMUL;
            step_in  = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            op      = OP_EXP;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            op       = OP_SCALE;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            op       = OP_DIFF;
            state_in = ST_WEIGH;
         end
         ST_WEIGH: begin
            op       = OP_WEIGH;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            op = OP_UPDATE;
            if (axis_ff == 2'd3) begin
               state_in = ST_FINISH;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_FINISH: begin
            // previous result must be gone before the output register reloads
            if (out_free) begin
               op       = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (op == OP_OUT) valid_in = 1'b1;
   end

   assign cmd.op   = op;
   assign cmd.axis = axis_ff;
   assign cmd.step = step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 2'd0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/jacs_dp.sv]
// ----------------------------------------------------------------------------
// jacs_dp
// Datapath: clamp, normalize, log2 by squaring, scale by power, exp2 by root
// table, blend into the kept level, round to the output.
// ----------------------------------------------------------------------------
module jacs_dp #(
   parameter int AXIS_FRAC_BITS   = 14,
   parameter int STATE_GUARD_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  jacs_pkg::jacs_cmd_type                cmd,
   output jacs_pkg::jacs_status_type             status,
   input  logic [1:0]                            req_type,
   input  logic signed [jacs_pkg::AXIS_W-1:0]    req_left_x_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0]    req_left_y_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0]    req_right_x_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0]    req_right_y_in,
   input  logic [jacs_pkg::POWER_W-1:0]          steering_power,
   input  logic [jacs_pkg::POWER_W-1:0]          throttle_power,
   input  logic [jacs_pkg::ALPHA_W-1:0]          steering_alpha,
   input  logic [jacs_pkg::ALPHA_W-1:0]          throttle_alpha,
   output logic signed [jacs_pkg::AXIS_W-1:0]    rsp_left_x_out,
   output logic signed [jacs_pkg::AXIS_W-1:0]    rsp_left_y_out,
   output logic signed [jacs_pkg::AXIS_W-1:0]    rsp_right_x_out,
   output logic signed [jacs_pkg::AXIS_W-1:0]    rsp_right_y_out
);
   import jacs_pkg::*;

   localparam int F   = AXIS_FRAC_BITS;
   localparam int G   = STATE_GUARD_BITS;
   localparam int S   = F + G;
   localparam int LW  = S + 2;
   localparam int DW  = S + 2;
   localparam int MW  = S + 1;
   localparam int MCW = $clog2(F);
   localparam int XW  = F + 18;
   localparam int NLW = $clog2(F + 1) + LOG_FRAC;
   localparam int EW  = NLW + POWER_W - 8;
   localparam int IPW = EW - LOG_FRAC;
   localparam int SHW = IPW + 7;
   localparam int WW  = S + 33;
   localparam int OW  = (S + 2 > AXIS_W) ? S + 2 : AXIS_W;

   localparam logic signed [XW-1:0] LIMIT = XW'(1) <<< F;
   localparam logic [S+1:0]         HALF  = (G == 0) ? '0 : (S+2)'(1) << (G - 1);

   logic [1:0]                  req_ff;
   logic [AXIS_W-1:0]           in_ff [4];
   logic signed [LW-1:0]        level_ff [4];
   logic [AXIS_W-1:0]           out_ff [4];
   logic [F-1:0]                ax_ff;
   logic [MCW-1:0]              m_ff;
   logic [31:0]                 y_ff;
   logic [LOG_FRAC-1:0]         frac_ff;
   logic [NLW-1:0]              nl_ff;
   logic [EW-1:0]               e_ff;
   logic [32:0]                 acc_ff;
   logic                        neg_ff;
   logic signed [LW-1:0]        target_ff;
   logic                        dneg_ff;
   logic [DW-1:0]               dmag_ff;
   logic [DW-1:0]               q_ff;

   // current axis selection
   logic [AXIS_W-1:0]           raw;
   logic [POWER_W-1:0]          pw_raw, pw_eff;
   logic [ALPHA_W-1:0]          al_raw, al_eff;
   logic signed [XW-1:0]        xs, xc, xabs;
   logic                        x_neg;
   logic [F:0]                  a;
   logic [MW-1:0]               direct;

   always_comb begin
      raw    = in_ff[cmd.axis];
      pw_raw = cmd.axis[0] ? throttle_power : steering_power;
      al_raw = cmd.axis[0] ? throttle_alpha : steering_alpha;
      pw_eff = (pw_raw < POWER_ONE) ? POWER_ONE : pw_raw;
      al_eff = (al_raw > ALPHA_ONE) ? ALPHA_ONE : al_raw;
      xs     = XW'($signed(raw));
      if (xs > LIMIT)       xc = LIMIT;
      else if (xs < -LIMIT) xc = -LIMIT;
      else                  xc = xs;
      x_neg  = xc[XW-1];
      xabs   = x_neg ? -xc : xc;
      a      = xabs[F:0];
      // zero, full scale and unity power all reduce to a plain shift
      direct = MW'(a) << G;
   end

   assign status.shortcut  = (a == '0) || a[F] || (pw_eff == POWER_ONE);
   assign status.norm_done = ax_ff[F-1];

   // log2 squaring step
   logic [63:0] sq;
   logic [32:0] sq_t;
   assign sq   = 64'(y_ff) * 64'(y_ff);
   assign sq_t = sq[63:31];

   // power scaling
   logic [NLW+POWER_W-1:0] eprod;
   assign eprod = (NLW+POWER_W)'(nl_ff) * (NLW+POWER_W)'(pw_eff);

   // exp2 root step
   logic [64:0]       xprod;
   logic [STEP_W-1:0] fp_idx;
   assign xprod  = 65'(acc_ff) * 65'(EXP_ROOT[cmd.step]);
   assign fp_idx = STEP_W'(LOG_FRAC - 1) - cmd.step;

   // final shift by the integer part
   logic [SHW-1:0] ipx;
   logic [WW-1:0]  wide;
   logic [MW-1:0]  scaled;
   always_comb begin
      ipx = SHW'(e_ff[EW-1:LOG_FRAC]) + SHW'(32);
      if (ipx >= SHW'(S)) wide = WW'(acc_ff) >> (ipx - SHW'(S));
      else                wide = WW'(acc_ff) << (SHW'(S) - ipx);
      scaled = wide[MW-1:0];
   end

   // blend
   logic signed [LW:0]   d, dabs;
   logic [DW+16:0]       wsum;
   logic signed [LW-1:0] lvl;
   always_comb begin
      lvl  = level_ff[cmd.axis];
      d    = {target_ff[LW-1], target_ff} - {lvl[LW-1], lvl};
      dabs = d[LW] ? -d : d;
      wsum = (DW+17)'(dmag_ff) * (DW+17)'(al_eff) + (DW+17)'(32768);
   end

   // output rounding, half away from zero
   logic [AXIS_W-1:0] rnd [4];
   always_comb begin
      logic signed [LW-1:0] lv;
      logic [LW-1:0]        lmag;
      logic [S+1:0]         r;
      logic [OW-1:0]        rw;
      for (int i = 0; i < 4; i++) begin
         lv     = level_ff[i];
         lmag   = lv[LW-1] ? LW'(-lv) : LW'(lv);
         r      = ((S+2)'(lmag) + HALF) >> G;
         rw     = OW'(r);
         rnd[i] = lv[LW-1] ? -rw[AXIS_W-1:0] : rw[AXIS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) level_ff[i] <= '0;
      end else begin
         case (cmd.op)
            OP_UPDATE: begin
               if (req_ff == REQ_CLEAR)     level_ff[cmd.axis] <= '0;
               else if (req_ff == REQ_SNAP) level_ff[cmd.axis] <= target_ff;
               else level_ff[cmd.axis] <= dneg_ff ? lvl - $signed(LW'(q_ff))
                                                  : lvl + $signed(LW'(q_ff));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD_IN: begin
            req_ff   <= req_type;
            in_ff[0] <= req_left_x_in;
            in_ff[1] <= req_left_y_in;
            in_ff[2] <= req_right_x_in;
            in_ff[3] <= req_right_y_in;
         end
         OP_PREP: begin
            neg_ff    <= x_neg;
            target_ff <= x_neg ? -$signed(LW'(direct)) : $signed(LW'(direct));
            ax_ff     <= a[F-1:0];
            m_ff      <= MCW'(F - 1);
         end
         OP_NORM: begin
            if (ax_ff[F-1]) begin
               y_ff    <= {ax_ff, {(32-F){1'b0}}};
               frac_ff <= '0;
            end else begin
               ax_ff <= ax_ff << 1;
               m_ff  <= m_ff - 1'b1;
            end
         end
         OP_LOG: begin
            if (sq_t[32]) begin
               y_ff    <= sq_t[32:1];
               frac_ff <= {frac_ff[LOG_FRAC-2:0], 1'b1};
            end else begin
               y_ff    <= sq_t[31:0];
               frac_ff <= {frac_ff[LOG_FRAC-2:0], 1'b0};
            end
         end
         OP_NLOG: nl_ff <= ((NLW'(F) - NLW'(m_ff)) << LOG_FRAC) - NLW'(frac_ff);
         OP_EMUL: begin
            e_ff   <= eprod[NLW+POWER_W-1:8];
            acc_ff <= 33'h1_0000_0000;
         end
         OP_EXP: begin
            if (e_ff[fp_idx]) acc_ff <= xprod[64:32];
         end
         OP_SCALE: target_ff <= neg_ff ? -$signed(LW'(scaled)) : $signed(LW'(scaled));
         OP_DIFF: begin
            dneg_ff <= d[LW];
            dmag_ff <= dabs[DW-1:0];
         end
         OP_WEIGH: q_ff <= wsum[DW+15:16];
         OP_OUT: begin
            for (int i = 0; i < 4; i++) out_ff[i] <= rnd[i];
         end
         default: ;
      endcase
   end

   assign rsp_left_x_out  = out_ff[0];
   assign rsp_left_y_out  = out_ff[1];
   assign rsp_right_x_out = out_ff[2];
   assign rsp_right_y_out = out_ff[3];

endmodule

[rtl/joystick_axis_curve_smoother.sv]
// Sequence: each axis in turn is prepared, then its difference, weight and
//   level update follow; for a curve that is not trivial (zero, full scale or
//   unity power), normalize, 24 log2 squaring steps, power scaling, 24 exp2
//   root steps and the final shift come between. A new request is taken only
//   in idle; the squaring and root multipliers serve the four axes in turn.
// Reset: synchronous, clears levels to zero and settings registers to defaults.
// ----------------------------------------------------------------------------
// joystick_axis_curve_smoother
// Four-axis expo curve with exponential smoothing, Q1.14 in and out.
// ----------------------------------------------------------------------------
module joystick_axis_curve_smoother #(
   parameter int AXIS_FRAC_BITS   = 14,
   parameter int STATE_GUARD_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic signed [jacs_pkg::AXIS_W-1:0] req_left_x_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0] req_left_y_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0] req_right_x_in,
   input  logic signed [jacs_pkg::AXIS_W-1:0] req_right_y_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [jacs_pkg::AXIS_W-1:0] rsp_left_x_out,
   output logic signed [jacs_pkg::AXIS_W-1:0] rsp_left_y_out,
   output logic signed [jacs_pkg::AXIS_W-1:0] rsp_right_x_out,
   output logic signed [jacs_pkg::AXIS_W-1:0] rsp_right_y_out,
   input  logic                               csr_write,
   input  logic [1:0]                         csr_index,
   input  logic [jacs_pkg::CSR_W-1:0]         csr_wdata
);
   import jacs_pkg::*;

   logic [POWER_W-1:0] steer_pw_ff, thr_pw_ff;
   logic [ALPHA_W-1:0] steer_al_ff, thr_al_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_pw_ff <= POWER_ONE;
         thr_pw_ff   <= POWER_ONE;
         steer_al_ff <= ALPHA_ONE;
         thr_al_ff   <= ALPHA_ONE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEER_POWER: steer_pw_ff <= csr_wdata[POWER_W-1:0];
            CSR_THR_POWER:   thr_pw_ff   <= csr_wdata[POWER_W-1:0];
            CSR_STEER_ALPHA: steer_al_ff <= csr_wdata[ALPHA_W-1:0];
            CSR_THR_ALPHA:   thr_al_ff   <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   jacs_cmd_type    cmd;
   jacs_status_type status;

   jacs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jacs_dp #(
      .AXIS_FRAC_BITS   (AXIS_FRAC_BITS),
      .STATE_GUARD_BITS (STATE_GUARD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_left_x_in   (req_left_x_in),
      .req_left_y_in   (req_left_y_in),
      .req_right_x_in  (req_right_x_in),
      .req_right_y_in  (req_right_y_in),
      .steering_power  (steer_pw_ff),
      .throttle_power  (thr_pw_ff),
      .steering_alpha  (steer_al_ff),
      .throttle_alpha  (thr_al_ff),
      .rsp_left_x_out  (rsp_left_x_out),
      .rsp_left_y_out  (rsp_left_y_out),
      .rsp_right_x_out (rsp_right_x_out),
      .rsp_right_y_out (rsp_right_y_out)
   );

   // an accepted request keeps the sequencer busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while sequencer idle");

   // a new result only appears at the end of a busy sequence
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a running request");

endmodule

[verif/joystick_axis_curve_smoother_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_axis_curve_smoother_tb
// Drives stick requests through the curve smoother under random idling on
// both sides and checks every response against a cycle-free predictor of the
// expo curve and smoothing filter, across several register settings.
// ----------------------------------------------------------------------------
module joystick_axis_curve_smoother_tb;
   import jacs_pkg::*;

   localparam int FRAC_BITS  = 14;
   localparam int GUARD_BITS = 8;
   localparam int LVL_FRAC   = FRAC_BITS + GUARD_BITS;
   localparam int WATCHDOG   = 20000;
   localparam int DRAIN      = 300;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] ax [4];
      bit                 fixed;
      logic signed [15:0] want [4];
   } stick_req_type;

   typedef struct {
      logic signed [15:0] ax [4];
   } stick_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = REQ_SMOOTH;
   logic signed [15:0] req_left_x_in = '0, req_left_y_in = '0;
   logic signed [15:0] req_right_x_in = '0, req_right_y_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_x_out, rsp_left_y_out, rsp_right_x_out, rsp_right_y_out;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_STEER_POWER;
   logic [CSR_W-1:0] csr_wdata = '0;

   joystick_axis_curve_smoother uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [11:0] pw_reg [2];   // 0 steering, 1 throttle
   logic [16:0] al_reg [2];
   longint      level [4];
   logic [31:0] root_tab [24];
   stick_rsp_type expected_q [$];
   int fails = 0, sent = 0, checked = 0, idle_cycles = 0;
   bit quiet = 1'b0, timed_out = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0, b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // magnitude of (a/2^F)^(pw/256) in Q.LVL_FRAC via log2/exp2
   function automatic longint unsigned curve_mag(longint unsigned a, int unsigned pw);
      int m = 0;
      longint unsigned y, frac = 0, nlog, e, fp, ip, acc, sh;
      while (m < 63 && (a >> (m + 1)) != 0) m++;
      y = a << (31 - m);
      for (int k = 0; k < 24; k++) begin
         y = (y * y) >> 31;
         frac <<= 1;
         if (y >= 64'h1_0000_0000) begin
            frac |= 1;
            y >>= 1;
         end
      end
      nlog = (longint'(FRAC_BITS - m) << 24) - frac;
      e = (nlog * pw) >> 8;
      ip = e >> 24;
      fp = e & 64'hFF_FFFF;
      acc = 64'h1_0000_0000;
      for (int k = 1; k <= 24; k++)
         if ((fp >> (24 - k)) & 1) acc = (acc * root_tab[k-1]) >> 32;
      if (32 + ip >= LVL_FRAC) begin
         sh = 32 + ip - LVL_FRAC;
         return sh >= 64 ? 0 : acc >> sh;
      end
      return acc << (LVL_FRAC - 32 - ip);
   endfunction

   function automatic longint shaped_axis(logic signed [15:0] raw, logic [11:0] pw_in);
      longint x = raw, lim = 1 << FRAC_BITS;
      longint unsigned a, mag;
      int unsigned pw = pw_in < POWER_ONE ? POWER_ONE : pw_in;
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      if (x == 0) return 0;
      a = x < 0 ? -x : x;
      if (a == lim) mag = 64'd1 << LVL_FRAC;
      else if (pw == POWER_ONE) mag = a << GUARD_BITS;
      else mag = curve_mag(a, pw);
      return x < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint ema_step(longint lv, longint tgt, logic [16:0] al_in);
      longint d = tgt - lv;
      longint unsigned mag = d < 0 ? -d : d, q;
      longint unsigned al = al_in > ALPHA_ONE ? ALPHA_ONE : al_in;
      q = (mag * al + 32768) >> 16;
      return d < 0 ? lv - longint'(q) : lv + longint'(q);
   endfunction

   function automatic logic signed [15:0] level_to_axis(longint s);
      longint unsigned mag = s < 0 ? -s : s;
      mag = (mag + (1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      return 16'(s < 0 ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic stick_rsp_type smoother_predict(stick_req_type r);
      stick_rsp_type o;
      longint tgt [4];
      for (int i = 0; i < 4; i++) tgt[i] = shaped_axis(r.ax[i], pw_reg[i % 2]);
      for (int i = 0; i < 4; i++) begin
         case (r.kind)
            REQ_CLEAR: level[i] = 0;
            REQ_SNAP:  level[i] = tgt[i];
            default:   level[i] = ema_step(level[i], tgt[i], al_reg[i % 2]);
         endcase
         o.ax[i] = level_to_axis(level[i]);
      end
      return o;
   endfunction

   task automatic csr_set(logic [1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_STEER_POWER: pw_reg[0] = val[11:0];
         CSR_THR_POWER:   pw_reg[1] = val[11:0];
         CSR_STEER_ALPHA: al_reg[0] = val[16:0];
         default:         al_reg[1] = val[16:0];
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && !timed_out) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // valid stays high after an accept unless an idle gap follows
   task automatic send_request(stick_req_type r);
      stick_rsp_type p;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_left_x_in <= r.ax[0];
      req_left_y_in <= r.ax[1];
      req_right_x_in <= r.ax[2];
      req_right_y_in <= r.ax[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = smoother_predict(r);
      if (r.fixed && p.ax != r.want) begin
         $display("%0t table row disagrees with predictor", $time);
         fails++;
      end
      if (r.fixed) p.ax = r.want;
      expected_q.push_back(p);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 32) - 16);
         2: return 16'(16384 - $urandom_range(0, 4));
         3: return 16'(-16384 + $urandom_range(0, 4));
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic random_phase(int n);
      stick_req_type r;
      for (int i = 0; i < n; i++) begin
         r.fixed = 1'b0;
         r.kind = $urandom_range(0, 9) < 7 ? REQ_SMOOTH : 2'($urandom_range(1, 3));
         for (int j = 0; j < 4; j++) r.ax[j] = rand_axis();
         send_request(r);
      end
   endtask

   // response check
   always @(posedge clock) begin
      stick_rsp_type got, exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.ax = '{rsp_left_x_out, rsp_left_y_out, rsp_right_x_out, rsp_right_y_out};
         if (expected_q.size() == 0) begin
            $display("%0t unexpected response %p", $time, got.ax);
            fails++;
         end else begin
            exp_r = expected_q.pop_front();
            checked++;
            for (int i = 0; i < 4; i++)
               if (got.ax[i] !== exp_r.ax[i]) begin
                  $display("%0t axis %0d: expected %0d, got %0d", $time, i,
                           exp_r.ax[i], got.ax[i]);
                  fails++;
               end
         end
      end
   end

   // response stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL");
         $finish;
      end
   end

   localparam logic signed [15:0] P1 = 16384, N1 = -16384;
   stick_req_type directed [] = '{
      '{REQ_SMOOTH, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
      '{REQ_SMOOTH, '{P1, N1, P1, N1}, 1, '{P1, N1, P1, N1}},
      // out of range inputs clamp to full scale
      '{REQ_SMOOTH, '{16'sh7FFF, 16'sh8000, 16'sh4001, -16'sd16385}, 1, '{P1, N1, P1, N1}},
      '{REQ_CLEAR, '{P1, P1, P1, P1}, 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
      '{REQ_SNAP, '{16'sd1, -16'sd1, 16'sd8192, -16'sd8192}, 1, '{16'sd1, -16'sd1, 16'sd8192, -16'sd8192}},
      // unused code acts as smooth
      '{2'd3, '{16'sd100, -16'sd100, 16'sd12345, 16'sd3}, 1, '{16'sd100, -16'sd100, 16'sd12345, 16'sd3}},
      '{REQ_SMOOTH, '{16'sd1, -16'sd1, 16'sd16383, -16'sd16383}, 0, '{default: 0}},
      '{REQ_SNAP, '{16'sd8192, -16'sd4096, 16'sd2, 16'sh7FFF}, 0, '{default: 0}},
      '{REQ_SMOOTH, '{-16'sd8192, 16'sd4096, -16'sd2, 16'sh8000}, 0, '{default: 0}},
      '{2'd3, '{16'sd5555, 16'sd0, -16'sd1, 16'sd16383}, 0, '{default: 0}},
      '{REQ_CLEAR, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
      '{REQ_SMOOTH, '{16'sd1, 16'sd3, 16'sd16383, -16'sd7}, 0, '{default: 0}}
   };

   initial begin
      pw_reg = '{POWER_ONE, POWER_ONE};
      al_reg = '{ALPHA_ONE, ALPHA_ONE};
      level = '{0, 0, 0, 0};
      root_tab[0] = 32'(int_sqrt(64'h8000_0000 << 32));
      for (int k = 1; k < 24; k++)
         root_tab[k] = 32'(int_sqrt(longint'(root_tab[k-1]) << 32));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         // the first six rows run at reset settings; the rest on a steep curve
         if (i == 6) begin
            wait_drained();
            csr_set(CSR_STEER_POWER, 17'd4095);
            csr_set(CSR_THR_POWER, 17'd640);
            csr_set(CSR_STEER_ALPHA, 17'd1);
            csr_set(CSR_THR_ALPHA, 17'h1FFFF);
         end
         send_request(directed[i]);
      end

      // settings: each phase drains first, then rewrites the registers
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               csr_set(CSR_STEER_POWER, 17'd0);   csr_set(CSR_THR_POWER, 17'd255);
               csr_set(CSR_STEER_ALPHA, 17'd0);   csr_set(CSR_THR_ALPHA, 17'd65536);
            end
            1: begin
               csr_set(CSR_STEER_POWER, 17'd257); csr_set(CSR_THR_POWER, 17'd4095);
               csr_set(CSR_STEER_ALPHA, 17'd65535); csr_set(CSR_THR_ALPHA, 17'd1);
            end
            default: begin
               csr_set(CSR_STEER_POWER, 17'($urandom_range(0, 4095)));
               csr_set(CSR_THR_POWER, 17'($urandom_range(0, 1200)));
               csr_set(CSR_STEER_ALPHA, 17'($urandom));
               csr_set(CSR_THR_ALPHA, 17'($urandom_range(0, 65536)));
            end
         endcase
         if (ph == 7) quiet = 1'b1;
         random_phase(180);
      end
      wait_drained();

      $display("Sent %0d requests, checked %0d responses over 10 register settings.",
               sent, checked);
      if (fails == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
